// ----- design/dba_pkg.sv -----
// ----------------------------------------------------------------------------
// dba_pkg
// Shared widths, word types and the arctangent table of the angle pipeline.
// ----------------------------------------------------------------------------
package dba_pkg;

  localparam int CompWidth   = 16;
  localparam int CordicSteps = 16;
  localparam int AtanLen     = 24;
  localparam int Steps       = (CordicSteps < AtanLen) ? CordicSteps : AtanLen;
  localparam int NormWidth   = 32;
  localparam int SqWidth     = 2 * NormWidth;
  localparam int RootBits    = SqWidth / 2;
  localparam int RemWidth    = RootBits + 2;
  localparam int DataWidth   = NormWidth + 4;
  localparam int AccWidth    = 34;
  localparam int ShiftWidth  = 5;
  localparam int AngWidth    = 16;

  localparam logic signed [AccWidth-1:0] QuarterTurn = AccWidth'(64'sd1073741824);

  typedef struct packed {
    logic                        mode;
    logic signed [NormWidth-1:0] x;
    logic signed [NormWidth-1:0] y;
    logic signed [NormWidth-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [SqWidth-1:0]  rad;
    logic [RemWidth-1:0] rem;
    logic [RootBits-1:0] root;
    vec_t                vec;
  } sq_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] xv;
    logic signed [DataWidth-1:0] yv;
    logic signed [AccWidth-1:0]  acc;
    logic                        zero;
  } lane_t;

  typedef lane_t [1:0] pair_t;

  function automatic logic signed [AccWidth-1:0] atan_unit(input logic [ShiftWidth-1:0] i);
    logic signed [AccWidth-1:0] v;
    case (i)
      5'd0:    v = AccWidth'(64'sd536870912);
      5'd1:    v = AccWidth'(64'sd316933406);
      5'd2:    v = AccWidth'(64'sd167458907);
      5'd3:    v = AccWidth'(64'sd85004756);
      5'd4:    v = AccWidth'(64'sd42667331);
      5'd5:    v = AccWidth'(64'sd21354465);
      5'd6:    v = AccWidth'(64'sd10679838);
      5'd7:    v = AccWidth'(64'sd5340245);
      5'd8:    v = AccWidth'(64'sd2670163);
      5'd9:    v = AccWidth'(64'sd1335087);
      5'd10:   v = AccWidth'(64'sd667544);
      5'd11:   v = AccWidth'(64'sd333772);
      5'd12:   v = AccWidth'(64'sd166886);
      5'd13:   v = AccWidth'(64'sd83443);
      5'd14:   v = AccWidth'(64'sd41722);
      5'd15:   v = AccWidth'(64'sd20861);
      5'd16:   v = AccWidth'(64'sd10430);
      5'd17:   v = AccWidth'(64'sd5215);
      5'd18:   v = AccWidth'(64'sd2608);
      5'd19:   v = AccWidth'(64'sd1304);
      5'd20:   v = AccWidth'(64'sd652);
      5'd21:   v = AccWidth'(64'sd326);
      5'd22:   v = AccWidth'(64'sd163);
      5'd23:   v = AccWidth'(64'sd81);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/dba_if.sv -----
// ----------------------------------------------------------------------------
// dba_in_if / dba_out_if
// Valid/ready channels for direction words and angle words.
// ----------------------------------------------------------------------------
interface dba_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic signed [dba_pkg::CompWidth-1:0] dir_x;
  logic signed [dba_pkg::CompWidth-1:0] dir_y;
  logic signed [dba_pkg::CompWidth-1:0] dir_z;
  modport source (output valid, mode, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, mode, dir_x, dir_y, dir_z, output ready);
endinterface

interface dba_out_if;
  logic                         valid;
  logic                         ready;
  logic [dba_pkg::AngWidth-1:0] first_angle;
  logic [dba_pkg::AngWidth-1:0] second_angle;
  modport source (output valid, first_angle, second_angle, input ready);
  modport sink   (input valid, first_angle, second_angle, output ready);
endinterface

// ----- design/direction_to_binary_angles.sv -----
// ----------------------------------------------------------------------------
// direction_to_binary_angles
// Direction vector to two binary angles: normalize, square, bit-serial
// square root chain, then two CORDIC atan2 lanes in a row of rotation cells.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     word
//  in_word   in   valid/ready   mode, dir_x, dir_y, dir_z
//  out_word  out  valid/ready   first_angle, second_angle
//
//  one word per cycle unless out_word is stalled; the registered stages in order:
//  4 front stages, 32 square root cells, pre-rotation, rotation cells, output
//  the whole pipeline advances together; it holds while out_word is stalled
//  synchronous reset clears all valid bits
// ----------------------------------------------------------------------------
module direction_to_binary_angles (
  input  logic       clk,
  input  logic       rst_n,
  dba_in_if.sink     in_word,
  dba_out_if.source  out_word
);

  localparam int Cw = dba_pkg::CompWidth;
  localparam int Nw = dba_pkg::NormWidth;
  localparam int Dw = dba_pkg::DataWidth;
  localparam int Aw = dba_pkg::AccWidth;
  localparam int Rb = dba_pkg::RootBits;
  localparam int St = dba_pkg::Steps;

  logic en;
  logic out_valid_r;
  logic [dba_pkg::AngWidth-1:0] ang0_r, ang1_r;

  assign en             = !out_valid_r || out_word.ready;
  assign in_word.ready  = en;
  assign out_word.valid = out_valid_r;
  assign out_word.first_angle  = ang0_r;
  assign out_word.second_angle = ang1_r;

  // stage 0: largest magnitude
  logic               v0_r;
  logic               mode0_r;
  logic signed [Cw-1:0] x0_r, y0_r, z0_r;
  logic [Cw-1:0]      m0_r;
  logic [Cw-1:0]      ax, ay, az, m_nxt;

  always_comb begin
    ax = in_word.dir_x[Cw-1] ? Cw'(-in_word.dir_x) : Cw'(in_word.dir_x);
    ay = in_word.dir_y[Cw-1] ? Cw'(-in_word.dir_y) : Cw'(in_word.dir_y);
    az = in_word.dir_z[Cw-1] ? Cw'(-in_word.dir_z) : Cw'(in_word.dir_z);
    m_nxt = ax;
    if (ay > m_nxt) m_nxt = ay;
    if (az > m_nxt) m_nxt = az;
  end

  // stage 1: normalizing shift
  logic                       v1_r;
  dba_pkg::vec_t              vec1_r;
  logic [dba_pkg::ShiftWidth-1:0] sh;

  always_comb begin
    sh = '0;
    for (int b = 0; b < Cw; b++) begin
      if (m0_r[b]) sh = dba_pkg::ShiftWidth'(Nw - 2 - b);
    end
    if (m0_r == '0) sh = '0;
  end

  // stage 2: squares, stage 3: sum
  logic               v2_r, v3_r;
  dba_pkg::vec_t      vec2_r, vec3_r;
  logic [Nw-1:0]      mx, mz;
  logic [2*Nw-1:0]    sqx_r, sqz_r, sum_r;

  assign mx = vec1_r.x[Nw-1] ? Nw'(-vec1_r.x) : Nw'(vec1_r.x);
  assign mz = vec1_r.z[Nw-1] ? Nw'(-vec1_r.z) : Nw'(vec1_r.z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_word.valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode0_r     <= in_word.mode;
      x0_r        <= in_word.dir_x;
      y0_r        <= in_word.dir_y;
      z0_r        <= in_word.dir_z;
      m0_r        <= m_nxt;
      vec1_r.mode <= mode0_r;
      vec1_r.x    <= Nw'(x0_r) <<< sh;
      vec1_r.y    <= Nw'(y0_r) <<< sh;
      vec1_r.z    <= Nw'(z0_r) <<< sh;
      vec2_r      <= vec1_r;
      sqx_r       <= mx * mx;
      sqz_r       <= mz * mz;
      vec3_r      <= vec2_r;
      sum_r       <= sqx_r + sqz_r;
    end
  end

  // square root chain
  logic         sv [Rb+1];
  dba_pkg::sq_t sd [Rb+1];

  always_comb begin
    sv[0]      = v3_r;
    sd[0].rad  = sum_r;
    sd[0].rem  = '0;
    sd[0].root = '0;
    sd[0].vec  = vec3_r;
  end

  for (genvar g = 0; g < Rb; g++) begin : g_sqrt
    dba_sqrt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .in_valid   (sv[g]),
      .in_data    (sd[g]),
      .out_valid_r(sv[g+1]),
      .out_data_r (sd[g+1])
    );
  end

  // atan2 operands
  dba_pkg::vec_t        vh;
  logic signed [Dw-1:0] hh, op_a0, op_b0, op_a1, op_b1;

  always_comb begin
    vh = sd[Rb].vec;
    hh = Dw'({1'b0, sd[Rb].root});
    if (!vh.mode) begin
      op_a0 = -Dw'(vh.y);
      op_b0 = hh;
      op_a1 = Dw'(vh.x);
      op_b1 = Dw'(vh.z);
    end else begin
      op_a0 = -Dw'(vh.z);
      op_b0 = Dw'(vh.y);
      op_a1 = Dw'(vh.x);
      op_b1 = hh;
    end
  end

  logic           cv [St+1];
  dba_pkg::pair_t cd [St+1];

  dba_cordic_pre u_pre (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (sv[Rb]),
    .a0         (op_a0),
    .b0         (op_b0),
    .a1         (op_a1),
    .b1         (op_b1),
    .out_valid_r(cv[0]),
    .out_data_r (cd[0])
  );

  for (genvar g = 0; g < St; g++) begin : g_rot
    dba_cordic_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .step       (dba_pkg::ShiftWidth'(g)),
      .in_valid   (cv[g]),
      .in_data    (cd[g]),
      .out_valid_r(cv[g+1]),
      .out_data_r (cd[g+1])
    );
  end

  // truncate toward zero to whole units
  logic [dba_pkg::AngWidth-1:0] q_nxt [2];
  logic signed [Aw-1:0]         qa [2];
  logic [Aw-1:0]                mag [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      mag[k] = cd[St][k].acc[Aw-1] ? Aw'(-cd[St][k].acc) : Aw'(cd[St][k].acc);
      qa[k]  = $signed(mag[k] >> 16);
      if (cd[St][k].acc[Aw-1]) qa[k] = -qa[k];
      q_nxt[k] = cd[St][k].zero ? '0 : qa[k][dba_pkg::AngWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cv[St];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang0_r <= q_nxt[0];
      ang1_r <= q_nxt[1];
    end
  end

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_word.valid)
    else $error("output valid after reset");
  a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(cv[St]) && $stable(sv[Rb]))
    else $error("pipeline moved while stalled");
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_word.valid && in_word.ready |=> v0_r)
    else $error("accepted word lost at entry");

endmodule

// ----- design/dba_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// dba_sqrt_cell
// One result bit of the restoring integer square root.
// ----------------------------------------------------------------------------
module dba_sqrt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  dba_pkg::sq_t   in_data,
  output logic           out_valid_r,
  output dba_pkg::sq_t   out_data_r
);

  logic [dba_pkg::RemWidth+1:0] cur;
  logic [dba_pkg::RemWidth+1:0] trial;
  dba_pkg::sq_t                 data_nxt;

  always_comb begin
    cur   = {in_data.rem, in_data.rad[dba_pkg::SqWidth-1 -: 2]};
    trial = {2'b00, in_data.root, 2'b01};
    data_nxt     = in_data;
    data_nxt.rad = {in_data.rad[dba_pkg::SqWidth-3:0], 2'b00};
    if (cur >= trial) begin
      data_nxt.rem  = dba_pkg::RemWidth'(cur - trial);
      data_nxt.root = {in_data.root[dba_pkg::RootBits-2:0], 1'b1};
    end else begin
      data_nxt.rem  = dba_pkg::RemWidth'(cur);
      data_nxt.root = {in_data.root[dba_pkg::RootBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= data_nxt;
    end
  end

endmodule

// ----- design/dba_cordic_pre.sv -----
// ----------------------------------------------------------------------------
// dba_cordic_pre
// Quarter-turn pre-rotation of both angle lanes.
// ----------------------------------------------------------------------------
module dba_cordic_pre (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [dba_pkg::DataWidth-1:0]  a0,
  input  logic signed [dba_pkg::DataWidth-1:0]  b0,
  input  logic signed [dba_pkg::DataWidth-1:0]  a1,
  input  logic signed [dba_pkg::DataWidth-1:0]  b1,
  output logic                                  out_valid_r,
  output dba_pkg::pair_t                        out_data_r
);

  dba_pkg::pair_t                       data_nxt;
  logic signed [dba_pkg::DataWidth-1:0] av [2];
  logic signed [dba_pkg::DataWidth-1:0] bv [2];

  always_comb begin
    av[0] = a0;
    bv[0] = b0;
    av[1] = a1;
    bv[1] = b1;
    for (int k = 0; k < 2; k++) begin
      data_nxt[k].zero = (av[k] == '0) && (bv[k] == '0);
      data_nxt[k].xv   = bv[k];
      data_nxt[k].yv   = av[k];
      data_nxt[k].acc  = '0;
      if (bv[k] < 0) begin
        if (av[k] >= 0) begin
          data_nxt[k].xv  = av[k];
          data_nxt[k].yv  = -bv[k];
          data_nxt[k].acc = dba_pkg::QuarterTurn;
        end else begin
          data_nxt[k].xv  = -av[k];
          data_nxt[k].yv  = bv[k];
          data_nxt[k].acc = -dba_pkg::QuarterTurn;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= data_nxt;
    end
  end

endmodule

// ----- design/dba_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// dba_cordic_cell
// One vectoring micro-rotation on both angle lanes.
// ----------------------------------------------------------------------------
module dba_cordic_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic [dba_pkg::ShiftWidth-1:0]  step,
  input  logic                            in_valid,
  input  dba_pkg::pair_t                  in_data,
  output logic                            out_valid_r,
  output dba_pkg::pair_t                  out_data_r
);

  dba_pkg::pair_t                       data_nxt;
  logic signed [dba_pkg::DataWidth-1:0] dx [2];
  logic signed [dba_pkg::DataWidth-1:0] dy [2];
  logic signed [dba_pkg::AccWidth-1:0]  ang;

  always_comb begin
    ang      = dba_pkg::atan_unit(step);
    data_nxt = in_data;
    for (int k = 0; k < 2; k++) begin
      dx[k] = in_data[k].yv >>> step;
      dy[k] = in_data[k].xv >>> step;
      if (in_data[k].yv >= 0) begin
        data_nxt[k].xv  = in_data[k].xv + dx[k];
        data_nxt[k].yv  = in_data[k].yv - dy[k];
        data_nxt[k].acc = in_data[k].acc + ang;
      end else begin
        data_nxt[k].xv  = in_data[k].xv - dx[k];
        data_nxt[k].yv  = in_data[k].yv + dy[k];
        data_nxt[k].acc = in_data[k].acc - ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= data_nxt;
    end
  end

endmodule

// ----- tb/tb_direction_to_binary_angles.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_direction_to_binary_angles
// Drives direction words through the angle pipeline and compares every angle
// word with a bit-exact integer CORDIC predictor (typed rows: table angles).
// A short table of corner vectors is followed by random vectors, with random
// idling on both sides, one long output stall and one drain pause.
// ----------------------------------------------------------------------------
module tb_direction_to_binary_angles;

  localparam int      NumRandom  = 1100;
  localparam int      IdleLimit  = 3000;
  localparam int      DrainWait  = 80;
  localparam longint  QuarterAcc = 64'sd1073741824;

  typedef struct packed {
    logic [dba_pkg::AngWidth-1:0] first_ang;
    logic [dba_pkg::AngWidth-1:0] second_ang;
  } angles_t;

  typedef struct {
    logic                          mode;
    logic [dba_pkg::CompWidth-1:0] x;
    logic [dba_pkg::CompWidth-1:0] y;
    logic [dba_pkg::CompWidth-1:0] z;
    bit                            typed;
    angles_t                       ang;
  } dir_row_t;

  logic clk;
  logic rst_n;

  dba_in_if  in_word ();
  dba_out_if out_word ();

  direction_to_binary_angles DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  longint atan_step_units [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  angles_t angle_q[$];
  int      errors;
  int      idle_cycles;
  int      words_out;
  bit      row_typed;
  angles_t row_ang;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [dba_pkg::AngWidth-1:0] atan2_units(longint a, longint b);
    longint xv, yv, acc, t, dx, dy, q;
    xv  = b;
    yv  = a;
    acc = 0;
    if (a == 0 && b == 0) return '0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv  = yv;
        yv  = -t;
        acc = QuarterAcc;
      end else begin
        xv  = -yv;
        yv  = t;
        acc = -QuarterAcc;
      end
    end
    for (int i = 0; i < dba_pkg::Steps; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv  += dx;
        yv  -= dy;
        acc += atan_step_units[i];
      end else begin
        xv  -= dx;
        yv  += dy;
        acc -= atan_step_units[i];
      end
    end
    q = (acc < 0) ? -((-acc) >>> 16) : (acc >>> 16);
    return q[dba_pkg::AngWidth-1:0];
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic angles_t predict_angles(logic mode,
                                             logic signed [dba_pkg::CompWidth-1:0] dx,
                                             logic signed [dba_pkg::CompWidth-1:0] dy,
                                             logic signed [dba_pkg::CompWidth-1:0] dz);
    longint x, y, z, m, h;
    longint unsigned sum;
    int s;
    angles_t r;
    x = dx;
    y = dy;
    z = dz;
    m = (x < 0) ? -x : x;
    if (((y < 0) ? -y : y) > m) m = (y < 0) ? -y : y;
    if (((z < 0) ? -z : z) > m) m = (z < 0) ? -z : z;
    s = 0;
    if (m != 0) begin
      while (s < 62 && (m << 1) < (64'sd1 << 31)) begin
        m <<= 1;
        s++;
      end
    end
    x   = x <<< s;
    y   = y <<< s;
    z   = z <<< s;
    sum = longint'(x * x) + longint'(z * z);
    h   = longint'(root_floor(sum));
    if (mode == 1'b0) begin
      r.first_ang  = atan2_units(-y, h);
      r.second_ang = atan2_units(x, z);
    end else begin
      r.first_ang  = atan2_units(-z, y);
      r.second_ang = atan2_units(x, h);
    end
    return r;
  endfunction

  // expectation is captured at the accepting edge
  always @(posedge clk) begin
    if (rst_n && in_word.valid && in_word.ready) begin
      if (row_typed) angle_q.push_back(row_ang);
      else angle_q.push_back(predict_angles(in_word.mode, in_word.dir_x,
                                            in_word.dir_y, in_word.dir_z));
    end
  end

  always @(posedge clk) begin
    angles_t e;
    if (rst_n && out_word.valid && out_word.ready) begin
      if (angle_q.size() == 0) begin
        $display("%0t: unexpected word first=%0d second=%0d", $time,
                 out_word.first_angle, out_word.second_angle);
        errors++;
      end else begin
        e = angle_q.pop_front();
        if (out_word.first_angle !== e.first_ang) begin
          $display("%0t: first_angle expected %0d actual %0d", $time, e.first_ang,
                   out_word.first_angle);
          errors++;
        end
        if (out_word.second_angle !== e.second_ang) begin
          $display("%0t: second_angle expected %0d actual %0d", $time, e.second_ang,
                   out_word.second_angle);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_word.valid && in_word.ready) || (out_word.valid && out_word.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off
  initial begin
    int gap;
    out_word.ready = 1'b0;
    words_out      = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = (words_out % 4 == 0) ? 0 : $urandom_range(0, 13);
      if (words_out == 150) gap = 400;
      if (gap > 0) begin
        out_word.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_word.ready <= 1'b1;
      @(negedge clk);
      while (!out_word.valid) @(negedge clk);
      @(posedge clk);
      words_out++;
    end
  end

  task automatic send_word(logic mode, logic [dba_pkg::CompWidth-1:0] x,
                           logic [dba_pkg::CompWidth-1:0] y,
                           logic [dba_pkg::CompWidth-1:0] z, bit typed, angles_t ang,
                           int gap);
    if (gap > 0) begin
      in_word.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word.valid <= 1'b1;
    in_word.mode  <= mode;
    in_word.dir_x <= x;
    in_word.dir_y <= y;
    in_word.dir_z <= z;
    row_typed     <= typed;
    row_ang       <= ang;
    @(negedge clk);
    while (!in_word.ready) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [dba_pkg::CompWidth-1:0] rand_comp();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return '0;
      3:       return dba_pkg::CompWidth'($signed($urandom_range(0, 8)) - 4);
      4:       return dba_pkg::CompWidth'($signed($urandom_range(0, 400)) - 200);
      default: return dba_pkg::CompWidth'($urandom());
    endcase
  endfunction

  initial begin
    dir_row_t dir_rows [14];
    logic [dba_pkg::CompWidth-1:0] rx, ry, rz;
    int gap;
    dir_rows = '{
      '{1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, '0},
      '{1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, '0},
      '{1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, '0},
      '{1'b1, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
      '{1'b0, 16'h8000, 16'h7fff, 16'h0000, 1'b0, '0},
      '{1'b1, 16'h7fff, 16'h8000, 16'h0001, 1'b0, '0},
      '{1'b0, 16'h0000, 16'h0000, 16'h8000, 1'b0, '0},
      '{1'b0, 16'h0001, 16'h0000, 16'h0000, 1'b0, '0},
      '{1'b1, 16'h0000, 16'h8000, 16'h0000, 1'b0, '0},
      '{1'b1, 16'h0000, 16'h0001, 16'hffff, 1'b0, '0},
      '{1'b0, 16'hffff, 16'hffff, 16'hffff, 1'b0, '0},
      '{1'b0, 16'h0000, 16'h7fff, 16'h0000, 1'b0, '0},
      '{1'b1, 16'h5555, 16'haaaa, 16'h5555, 1'b0, '0},
      '{1'b0, 16'haaaa, 16'h5555, 16'haaaa, 1'b0, '0}
    };
    errors        = 0;
    rst_n         = 1'b0;
    in_word.valid = 1'b0;
    in_word.mode  = 1'b0;
    in_word.dir_x = '0;
    in_word.dir_y = '0;
    in_word.dir_z = '0;
    row_typed     = 1'b0;
    row_ang       = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].mode, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                dir_rows[i].typed, dir_rows[i].ang, $urandom_range(0, 3));
    end
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 600) begin
        in_word.valid <= 1'b0;
        while (angle_q.size() != 0) @(posedge clk);
      end
      rx  = rand_comp();
      ry  = rand_comp();
      rz  = rand_comp();
      gap = ((n / 50) % 3 == 0) ? 0 : $urandom_range(0, 13);
      send_word(1'($urandom_range(0, 1)), rx, ry, rz, 1'b0, '0, gap);
    end
    in_word.valid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/dba_pkg.sv
design/dba_if.sv
design/dba_sqrt_cell.sv
design/dba_cordic_pre.sv
design/dba_cordic_cell.sv
design/direction_to_binary_angles.sv
tb/tb_direction_to_binary_angles.sv
